### rtl/vtaf_pkg.sv
// ----------------------------------------------------------------------------
// vtaf_pkg: shared types and constants of the value to ASCII formatter
// Command codes, digit cell control, sequencer states and the digit
// symbol function.
// ----------------------------------------------------------------------------
package vtaf_pkg;

	localparam int unsigned CmdWidth   = 3;
	localparam int unsigned SizeWidth  = 2;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned CharWidth  = 8;
	localparam int unsigned DigitWidth = 4;

	// The largest magnitude is 2**63, which has 19 decimal digits.
	localparam int unsigned NumCells   = 19;
	localparam int unsigned RemWidth   = $clog2(NumCells + 1);
	localparam int unsigned CntWidth   = $clog2(ValueWidth);

	localparam logic [CmdWidth-1:0] CMD_RAW    = 3'd0;
	localparam logic [CmdWidth-1:0] CMD_SDEC   = 3'd1;
	localparam logic [CmdWidth-1:0] CMD_UDEC   = 3'd2;
	localparam logic [CmdWidth-1:0] CMD_OCT    = 3'd3;
	localparam logic [CmdWidth-1:0] CMD_HEXLO  = 3'd4;
	localparam logic [CmdWidth-1:0] CMD_HEXUP  = 3'd5;
	localparam logic [CmdWidth-1:0] CMD_ESCAPE = 3'd6;

	localparam logic [SizeWidth-1:0] SIZE_LONG  = 2'd1;
	localparam logic [SizeWidth-1:0] SIZE_SHORT = 2'd2;

	localparam logic [CharWidth-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CharWidth-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CharWidth-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CharWidth-1:0] CHAR_BSLASH  = 8'h5C;
	localparam logic [CharWidth-1:0] CHAR_X       = 8'h78;
	localparam logic [CharWidth-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CharWidth-1:0] CHAR_DEL     = 8'h7F;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_DOUBLE,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		radix_t   radix;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_ESC
	} prefix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_CONVERT,
		ST_PREFIX,
		ST_SKIP,
		ST_DIGITS
	} state_t;

	function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d,
		input logic upper);
		logic [CharWidth-1:0] ext;
		ext = {{(CharWidth - DigitWidth){1'b0}}, d};
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + ext;
		end else if (upper) begin
			digit_char = CHAR_UPPER_A + ext - 8'd10;
		end else begin
			digit_char = CHAR_LOWER_A + ext - 8'd10;
		end
	endfunction

endpackage

### rtl/vtaf_if.sv
// ----------------------------------------------------------------------------
// vtaf_if: request and character channels of the formatter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface vtaf_req_if import vtaf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CmdWidth-1:0]   command;
	logic [SizeWidth-1:0]  size_mod;
	logic [ValueWidth-1:0] value;
	logic [CharWidth-1:0]  byte_in;

	modport source (output valid, output command, output size_mod, output value,
		output byte_in, input ready);
	modport sink (input valid, input command, input size_mod, input value,
		input byte_in, output ready);
endinterface

interface vtaf_char_if import vtaf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CharWidth-1:0] char_out;
	logic                 last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

### rtl/vtaf_cell.sv
// ----------------------------------------------------------------------------
// vtaf_cell: one digit cell of the conversion chain
// Holds one digit in the selected radix. A doubling step takes the carry of
// the lower cell as the new least significant bit; a shift step takes the
// lower cell's digit so the row can be read out from the top.
// ----------------------------------------------------------------------------
module vtaf_cell import vtaf_pkg::*; (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic                  carry_in,
	input  logic [DigitWidth-1:0] digit_in,
	output logic                  carry_out,
	output logic [DigitWidth-1:0] digit
);

	logic [DigitWidth-1:0] digit_q;
	logic [DigitWidth-1:0] half;
	logic [DigitWidth:0]   twice;
	logic [DigitWidth:0]   reduced;

	// Since the radix is even, 2d + cin reaches the radix exactly when d
	// reaches half of it, so the carry does not ripple along the row.
	always_comb begin
		unique case (ctrl.radix)
			RADIX_DEC: half = 4'd5;
			RADIX_OCT: half = 4'd4;
			default:   half = 4'd8;
		endcase
		twice     = {digit_q, carry_in};
		carry_out = (digit_q >= half);
		reduced   = carry_out ? (twice - {half, 1'b0}) : twice;
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_HOLD:   digit_q <= digit_q;
			OP_CLEAR:  digit_q <= '0;
			OP_DOUBLE: digit_q <= reduced[DigitWidth-1:0];
			OP_SHIFT:  digit_q <= digit_in;
			default:   digit_q <= digit_q;
		endcase
	end

	assign digit = digit_q;

endmodule

### rtl/value_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// value_to_ascii_formatter: integer and character to ASCII converter
// Converts one request into its ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command, size_mod, value and byte_in. A request is taken
//   only while the block is idle. rsp carries one character per transfer,
//   with last set on the final character of the request. A request that
//   produces nothing (escaped zero byte, unused command) is taken and dropped.
//   Numeric requests load the magnitude into a row of 19 digit cells by 64
//   doubling steps, one bit per cycle, then a leading-zero pass, then one
//   character per cycle while the receiver is ready. A raw or printable
//   character passes through the single state into the output register.
//   The next request is accepted the cycle after the final character enters
//   the output register. When the receiver stalls, the output register holds
//   its character until the transfer completes and the row shifts out no
//   digits, but conversion and the leading-zero pass go on.
//   Reset clears the sequencer and the output valid flag; the block comes
//   out of reset idle and ready.
// ----------------------------------------------------------------------------
module value_to_ascii_formatter import vtaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vtaf_req_if.sink    req,
	vtaf_char_if.source rsp
);

	state_t                state_q;
	state_t                state_d;
	radix_t                radix_q;
	prefix_t               pfx_q;
	logic                  pfx_idx_q;
	logic                  upper_q;
	logic [RemWidth-1:0]   min_q;
	logic [RemWidth-1:0]   rem_q;
	logic [CntWidth-1:0]   cnt_q;
	logic [ValueWidth-1:0] mag_q;
	logic [CharWidth-1:0]  single_q;

	logic                  out_valid_q;
	logic [CharWidth-1:0]  char_q;
	logic                  last_q;

	logic                  accept;
	logic                  load_ok;
	logic                  emit;
	logic [CharWidth-1:0]  emit_char;
	logic                  emit_last;
	logic                  shift_row;
	cell_ctrl_t            cell_ctrl;

	logic [DigitWidth-1:0] digit [NumCells];
	logic [NumCells:0]     carry;
	logic [DigitWidth-1:0] top_digit;

	// Request decode
	logic [ValueWidth-1:0] sx;
	logic [ValueWidth-1:0] umag;
	logic [ValueWidth-1:0] new_mag;
	logic                  new_neg;
	logic                  esc_hex;
	state_t                start_state;
	radix_t                new_radix;
	prefix_t               new_pfx;
	logic                  new_upper;
	logic [RemWidth-1:0]   new_min;

	assign accept  = req.valid && req.ready;
	assign load_ok = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		if (req.size_mod == SIZE_LONG) begin
			sx = req.value;
		end else if (req.size_mod == SIZE_SHORT) begin
			sx = {{(ValueWidth - 16){req.value[15]}}, req.value[15:0]};
		end else begin
			sx = {{(ValueWidth - 32){req.value[31]}}, req.value[31:0]};
		end
		if (req.size_mod == SIZE_SHORT) begin
			umag = {{(ValueWidth - 16){1'b0}}, req.value[15:0]};
		end else begin
			umag = {{(ValueWidth - 32){1'b0}}, req.value[31:0]};
		end
		esc_hex = (req.byte_in < CHAR_SPACE) || (req.byte_in >= CHAR_DEL);

		new_neg     = 1'b0;
		new_mag     = umag;
		new_radix   = RADIX_DEC;
		new_pfx     = PFX_NONE;
		new_upper   = 1'b0;
		new_min     = RemWidth'(1);
		start_state = ST_IDLE;
		unique case (req.command)
			CMD_RAW: begin
				start_state = ST_SINGLE;
			end
			CMD_SDEC: begin
				new_neg     = sx[ValueWidth-1];
				new_mag     = new_neg ? (~sx + 64'd1) : sx;
				new_pfx     = new_neg ? PFX_MINUS : PFX_NONE;
				start_state = ST_CONVERT;
			end
			CMD_UDEC: begin
				start_state = ST_CONVERT;
			end
			CMD_OCT: begin
				new_radix   = RADIX_OCT;
				start_state = ST_CONVERT;
			end
			CMD_HEXLO: begin
				new_radix   = RADIX_HEX;
				start_state = ST_CONVERT;
			end
			CMD_HEXUP: begin
				new_radix   = RADIX_HEX;
				new_upper   = 1'b1;
				start_state = ST_CONVERT;
			end
			CMD_ESCAPE: begin
				if (req.byte_in == '0) begin
					start_state = ST_IDLE;
				end else if (esc_hex) begin
					new_mag     = {{(ValueWidth - CharWidth){1'b0}}, req.byte_in};
					new_radix   = RADIX_HEX;
					new_upper   = 1'b1;
					new_pfx     = PFX_ESC;
					new_min     = RemWidth'(2);
					start_state = ST_CONVERT;
				end else begin
					start_state = ST_SINGLE;
				end
			end
			default: begin
				start_state = ST_IDLE;
			end
		endcase
	end

	// Digit cell row
	assign carry[0]  = mag_q[ValueWidth-1];
	assign top_digit = digit[NumCells-1];

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		logic [DigitWidth-1:0] lower_digit;
		if (i == 0) begin : g_first
			assign lower_digit = '0;
		end else begin : g_rest
			assign lower_digit = digit[i-1];
		end
		vtaf_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.carry_in  (carry[i]),
			.digit_in  (lower_digit),
			.carry_out (carry[i+1]),
			.digit     (digit[i])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = start_state;
				end
			end
			ST_SINGLE: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			ST_CONVERT: begin
				if (cnt_q == CntWidth'(ValueWidth - 1)) begin
					state_d = (pfx_q == PFX_NONE) ? ST_SKIP : ST_PREFIX;
				end
			end
			ST_PREFIX: begin
				if (load_ok && (pfx_q == PFX_MINUS || pfx_idx_q)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!(top_digit == '0 && rem_q > min_q)) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (load_ok && rem_q == RemWidth'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		emit            = 1'b0;
		emit_char       = single_q;
		emit_last       = 1'b0;
		shift_row       = 1'b0;
		cell_ctrl.op    = OP_HOLD;
		cell_ctrl.radix = radix_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cell_ctrl.op = OP_CLEAR;
				end
			end
			ST_SINGLE: begin
				emit      = load_ok;
				emit_last = 1'b1;
			end
			ST_CONVERT: begin
				cell_ctrl.op = OP_DOUBLE;
			end
			ST_PREFIX: begin
				emit = load_ok;
				if (pfx_q == PFX_MINUS) begin
					emit_char = CHAR_MINUS;
				end else if (pfx_idx_q) begin
					emit_char = CHAR_X;
				end else begin
					emit_char = CHAR_BSLASH;
				end
			end
			ST_SKIP: begin
				shift_row = (top_digit == '0) && (rem_q > min_q);
			end
			ST_DIGITS: begin
				emit      = load_ok;
				emit_char = digit_char(top_digit, upper_q);
				emit_last = (rem_q == RemWidth'(1));
				shift_row = load_ok;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (shift_row) begin
			cell_ctrl.op = OP_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			pfx_idx_q   <= 1'b0;
			rem_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				cnt_q     <= '0;
				pfx_idx_q <= 1'b0;
				rem_q     <= RemWidth'(NumCells);
			end else begin
				if (state_q == ST_CONVERT) begin
					cnt_q <= cnt_q + CntWidth'(1);
				end
				if (state_q == ST_PREFIX && load_ok) begin
					pfx_idx_q <= 1'b1;
				end
				if (shift_row) begin
					rem_q <= rem_q - RemWidth'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q  <= new_radix;
			pfx_q    <= new_pfx;
			upper_q  <= new_upper;
			min_q    <= new_min;
			mag_q    <= new_mag;
			single_q <= req.byte_in;
		end else if (state_q == ST_CONVERT) begin
			mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
		end
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.char_out = char_q;
	assign rsp.last     = last_q;

	// The magnitude always fits the row, so the top cell never overflows.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONVERT) |-> !carry[NumCells])
		else $error("digit row overflow during conversion");

	a_skip_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP) |-> (rem_q >= min_q && rem_q != '0))
		else $error("digit count fell below its minimum");

	a_last_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_DIGITS && state_q == ST_IDLE) |-> (out_valid_q && last_q))
		else $error("request finished without a final character");

	a_prefix_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREFIX) |-> (pfx_q != PFX_NONE))
		else $error("prefix state without a prefix");

	a_convert_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONVERT && cnt_q == CntWidth'(ValueWidth - 1)) |=>
		(state_q != ST_CONVERT))
		else $error("conversion ran past its bit count");

endmodule
